// ----- hw/rtl/avfs_pkg.sv -----
package avfs_pkg;

   localparam int CNT_BITS = 13;
   localparam int FN_BITS = 32;
   localparam int SUM_BITS = 48;
   localparam int SQ_BITS = 64;
   localparam int WIDE_BITS = 128;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 48;

   localparam longint PI_Q = 64'sd52707179;
   localparam longint TWO_PI_Q = 64'sd105414357;
   localparam logic [62:0] MAX63 = '1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PARTICLE_COUNT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEPS_PER_FRAME = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_TIME = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROT_DIFFUSION = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNWRAPPED_MODE = 3'd4;

   typedef struct packed {
      logic signed [FN_BITS-1:0]  frame_number;
      logic [FN_BITS-1:0]         index_step;
      logic signed [SUM_BITS-1:0] sum_delta;
      logic [SUM_BITS-1:0]        sum_abs;
      logic [SQ_BITS-1:0]         sum_sq;
   } job_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   function automatic logic [62:0] sat63(input logic [WIDE_BITS-1:0] x);
      if (x[WIDE_BITS-1:63] != '0) begin
         return MAX63;
      end
      return x[62:0];
   endfunction

   function automatic logic [63:0] sat_signed(input logic [WIDE_BITS-1:0] x,
                                              input logic neg);
      logic [63:0] lim;
      lim = 64'h8000_0000_0000_0000;
      if (!neg) begin
         return {1'b0, sat63(x)};
      end
      if (x > WIDE_BITS'(lim)) begin
         return lim;
      end
      return 64'(0) - x[63:0];
   endfunction

endpackage

// ----- hw/rtl/avfs_front.sv -----
module avfs_front import avfs_pkg::*; #(
   parameter int MAX_PARTICLES = 4096,
   parameter int ANGLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [ANGLE_BITS-1:0] angle,
   input  logic signed [FN_BITS-1:0]    frame_number,
   input  logic                         frame_last,
   input  logic [CNT_BITS-1:0]          n,
   input  logic                         unwrapped,
   output logic                         push,
   output job_type                      job
);

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int DW = ((ANGLE_BITS > 27) ? ANGLE_BITS : 27) + 2;
   localparam int AccW = ((DW > SUM_BITS) ? DW : SUM_BITS) + 2;

   typedef struct packed {
      logic                      valid;
      logic                      used;
      logic                      last;
      logic                      cand;
      logic signed [FN_BITS-1:0] fn;
      logic [FN_BITS-1:0]        k;
   } stage_type;

   logic signed [ANGLE_BITS-1:0] mem [MAX_PARTICLES];

   logic [CNT_BITS-1:0]       pos_ff, pos_in;
   logic                      loaded_ff, loaded_in;
   logic signed [FN_BITS-1:0] prev_fn_ff, prev_fn_in;
   stage_type                 s1_ff, s1_in, s2_ff, s3_ff;
   logic signed [ANGLE_BITS-1:0] a1_ff, old1_ff;
   logic signed [DW-1:0]      d2_ff, d2_in, d3_ff;
   logic [DW-1:0]             m3_ff, m3_in;
   logic [SUM_BITS-1:0]       sq3_ff, sq3_in;
   logic signed [SUM_BITS-1:0] sd_ff, sd_in;
   logic [SUM_BITS-1:0]       sa_ff, sa_in;
   logic [SQ_BITS-1:0]        ss_ff, ss_in;

   logic                      sample;
   logic [AW-1:0]             addr;
   logic signed [DW-1:0]      diff;
   logic [DW-1:0]             mag;
   logic [31:0]               mc;
   logic signed [AccW-1:0]    sd_sum;
   logic [AccW-1:0]           sa_sum;
   logic [SQ_BITS:0]          ss_sum;
   logic signed [SUM_BITS-1:0] sd_next;
   logic [SUM_BITS-1:0]       sa_next;
   logic [SQ_BITS-1:0]        ss_next;

   assign sample = pos_ff < n;
   assign addr = AW'(pos_ff);

   always_comb begin
      s1_in.valid = accept;
      s1_in.used = sample && loaded_ff;
      s1_in.last = frame_last;
      s1_in.cand = loaded_ff && (frame_number > prev_fn_ff);
      s1_in.fn = frame_number;
      s1_in.k = FN_BITS'(33'(frame_number) - 33'(prev_fn_ff));
      pos_in = pos_ff;
      loaded_in = loaded_ff;
      prev_fn_in = prev_fn_ff;
      if (accept) begin
         if (frame_last) begin
            pos_in = '0;
            loaded_in = 1'b1;
            prev_fn_in = frame_number;
         end else if (sample) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // unless unwrapped, shift once by 2*pi toward (-pi, pi]
   always_comb begin
      diff = DW'(a1_ff) - DW'(old1_ff);
      d2_in = diff;
      if (!unwrapped) begin
         if (64'(diff) > PI_Q) begin
            d2_in = diff - DW'(TWO_PI_Q);
         end else if (64'(diff) <= -PI_Q) begin
            d2_in = diff + DW'(TWO_PI_Q);
         end
      end
   end

   always_comb begin
      mag = d2_ff[DW-1] ? DW'(0) - d2_ff : d2_ff;
      mc = (64'(mag) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(mag);
      m3_in = mag;
      sq3_in = SUM_BITS'((64'(mc) * 64'(mc)) >> 16);
   end

   always_comb begin
      sd_sum = AccW'(sd_ff) + (s3_ff.used ? AccW'(d3_ff) : AccW'(0));
      sa_sum = AccW'(sa_ff) + (s3_ff.used ? AccW'(m3_ff) : AccW'(0));
      ss_sum = (SQ_BITS+1)'(ss_ff) + (s3_ff.used ? (SQ_BITS+1)'(sq3_ff) : (SQ_BITS+1)'(0));
      if (sd_sum > AccW'(48'sh7FFF_FFFF_FFFF)) begin
         sd_next = 48'sh7FFF_FFFF_FFFF;
      end else if (sd_sum < -AccW'(48'sh7FFF_FFFF_FFFF) - AccW'(1)) begin
         sd_next = 48'sh8000_0000_0000;
      end else begin
         sd_next = SUM_BITS'(sd_sum);
      end
      sa_next = (sa_sum > AccW'({SUM_BITS{1'b1}})) ? '1 : SUM_BITS'(sa_sum);
      ss_next = ss_sum[SQ_BITS] ? '1 : ss_sum[SQ_BITS-1:0];
   end

   assign push = s3_ff.valid && s3_ff.last && s3_ff.cand;

   always_comb begin
      job.frame_number = s3_ff.fn;
      job.index_step = s3_ff.k;
      job.sum_delta = sd_next;
      job.sum_abs = sa_next;
      job.sum_sq = ss_next;
   end

   always_comb begin
      sd_in = sd_ff;
      sa_in = sa_ff;
      ss_in = ss_ff;
      if (s3_ff.valid) begin
         if (s3_ff.last) begin
            sd_in = '0;
            sa_in = '0;
            ss_in = '0;
         end else begin
            sd_in = sd_next;
            sa_in = sa_next;
            ss_in = ss_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && sample) begin
         old1_ff <= mem[addr];
         mem[addr] <= angle;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= angle;
      d2_ff <= d2_in;
      d3_ff <= d2_ff;
      m3_ff <= m3_in;
      sq3_ff <= sq3_in;
      if (reset) begin
         pos_ff <= '0;
         loaded_ff <= 1'b0;
         prev_fn_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         sd_ff <= '0;
         sa_ff <= '0;
         ss_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         loaded_ff <= loaded_in;
         prev_fn_ff <= prev_fn_in;
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         sd_ff <= sd_in;
         sa_ff <= sa_in;
         ss_ff <= ss_in;
      end
   end

endmodule

// ----- hw/rtl/avfs_queue.sv -----
module avfs_queue import avfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    empty,
   output job_type head_job,
   output logic [3:0] count
);

   localparam int DEPTH = 8;

   job_type    entry_ff [DEPTH];
   logic [2:0] head_ff, tail_ff;
   logic [3:0] count_ff;
   logic       do_pop;

   assign empty = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head_job = entry_ff[head_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_job;
      end
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (do_pop) begin
            head_ff <= head_ff + 1'b1;
         end
         count_ff <= count_ff + 4'(push) - 4'(do_pop);
      end
   end

endmodule

// ----- hw/rtl/avfs_arith.sv -----
module avfs_arith import avfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  arith_req_type        req,
   input  logic [WIDE_BITS-1:0] a,
   input  logic [WIDE_BITS-1:0] b,
   output logic                 done,
   output logic [WIDE_BITS-1:0] result
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type            state_ff;
   arith_op_type         op_ff;
   logic [WIDE_BITS-1:0] x_ff, y_ff, acc_ff;
   logic [WIDE_BITS-1:0] rem_ff;
   logic [6:0]           cnt_ff;
   logic                 done_ff;

   logic [WIDE_BITS:0]   trial;
   logic [WIDE_BITS-1:0] root_try;

   assign done = done_ff;
   assign result = acc_ff;
   assign trial = {rem_ff, x_ff[WIDE_BITS-1]};
   assign root_try = acc_ff + y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (req.start) begin
                  state_ff <= RUN;
                  op_ff <= req.op;
                  x_ff <= a;
                  y_ff <= (req.op == OP_SQRT) ? (WIDE_BITS'(1) << 126) : b;
                  acc_ff <= '0;
                  rem_ff <= '0;
                  cnt_ff <= '0;
               end
            end
            RUN: begin
               unique case (op_ff)
                  OP_MUL: begin
                     if (y_ff == '0) begin
                        state_ff <= IDLE;
                        done_ff <= 1'b1;
                     end else begin
                        if (y_ff[0]) begin
                           acc_ff <= acc_ff + x_ff;
                        end
                        x_ff <= x_ff << 1;
                        y_ff <= y_ff >> 1;
                     end
                  end
                  OP_DIV: begin
                     if (trial >= {1'b0, y_ff}) begin
                        rem_ff <= WIDE_BITS'(trial - {1'b0, y_ff});
                        acc_ff <= {acc_ff[WIDE_BITS-2:0], 1'b1};
                     end else begin
                        rem_ff <= trial[WIDE_BITS-1:0];
                        acc_ff <= {acc_ff[WIDE_BITS-2:0], 1'b0};
                     end
                     x_ff <= x_ff << 1;
                     cnt_ff <= cnt_ff + 1'b1;
                     if (cnt_ff == '1) begin
                        state_ff <= IDLE;
                        done_ff <= 1'b1;
                     end
                  end
                  default: begin
                     if (x_ff >= root_try) begin
                        x_ff <= x_ff - root_try;
                        acc_ff <= (acc_ff >> 1) + y_ff;
                     end else begin
                        acc_ff <= acc_ff >> 1;
                     end
                     y_ff <= y_ff >> 2;
                     if (y_ff == WIDE_BITS'(1)) begin
                        state_ff <= IDLE;
                        done_ff <= 1'b1;
                     end
                  end
               endcase
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/avfs_back.sv -----
module avfs_back import avfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_ready,
   input  job_type             job,
   output logic                job_pop,
   input  logic [CNT_BITS-1:0] n,
   input  logic [31:0]         steps,
   input  logic [47:0]         step_time,
   input  logic [31:0]         dr,
   input  logic                rsp_pop,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_out_frame_number,
   output logic [62:0]         rsp_total_real_time,
   output logic [62:0]         rsp_total_scaled_time,
   output logic signed [63:0]  rsp_mean_rate,
   output logic signed [63:0]  rsp_mean_rate_scaled,
   output logic [62:0]         rsp_mean_abs_rate,
   output logic [62:0]         rsp_rms_rate
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KSTEP,
      ST_DT,
      ST_DTS,
      ST_DEN,
      ST_DEN2,
      ST_QMEAN,
      ST_QSCALED,
      ST_QABS,
      ST_QMS,
      ST_ROOT,
      ST_QRMS,
      ST_WRITE
   } state_type;

   state_type            state_ff;
   job_type              job_ff;
   logic                 issued_ff;
   logic [WIDE_BITS-1:0] p_ff, den_ff, den2_ff;
   logic [62:0]          dt_ff, dts_ff, qabs_ff, qrms_ff;
   logic [63:0]          qmean_ff, qscaled_ff;
   logic [62:0]          er_ff, es_ff;
   logic                 out_valid_ff;
   logic signed [31:0]   o_fn_ff;
   logic [62:0]          o_er_ff, o_es_ff, o_abs_ff, o_rms_ff;
   logic signed [63:0]   o_mean_ff, o_scaled_ff;

   arith_req_type        areq;
   logic [WIDE_BITS-1:0] aa, ab, ares;
   logic                 adone;
   logic                 neg;
   logic [SUM_BITS-1:0]  mag;
   logic [31:0]          drp;
   logic [62:0]          dt_new, er_in, es_in;
   logic [63:0]          er_sum, es_sum;

   avfs_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (areq),
      .a      (aa),
      .b      (ab),
      .done   (adone),
      .result (ares)
   );

   assign neg = job_ff.sum_delta[SUM_BITS-1];
   assign mag = neg ? SUM_BITS'(0) - job_ff.sum_delta : job_ff.sum_delta;
   assign drp = (dr == '0) ? 32'd1 : dr;
   assign dt_new = sat63(ares >> 16);
   assign job_pop = (state_ff == ST_IDLE) && job_ready;
   assign er_sum = 64'(er_ff) + 64'(dt_ff);
   assign es_sum = 64'(es_ff) + 64'(dts_ff);
   assign er_in = er_sum[63] ? MAX63 : er_sum[62:0];
   assign es_in = es_sum[63] ? MAX63 : es_sum[62:0];

   always_comb begin
      areq.start = (state_ff != ST_IDLE) && (state_ff != ST_WRITE) && !issued_ff;
      areq.op = OP_MUL;
      aa = '0;
      ab = '0;
      unique case (state_ff)
         ST_KSTEP: begin
            aa = WIDE_BITS'(job_ff.index_step);
            ab = WIDE_BITS'(steps);
         end
         ST_DT: begin
            aa = p_ff;
            ab = WIDE_BITS'(step_time);
         end
         ST_DTS: begin
            aa = WIDE_BITS'(dt_ff);
            ab = WIDE_BITS'(dr);
         end
         ST_DEN: begin
            aa = WIDE_BITS'(dt_ff);
            ab = WIDE_BITS'(n);
         end
         ST_DEN2: begin
            aa = den_ff;
            ab = WIDE_BITS'(drp);
         end
         ST_QMEAN: begin
            areq.op = OP_DIV;
            aa = WIDE_BITS'(mag) << 40;
            ab = den_ff;
         end
         ST_QSCALED: begin
            areq.op = OP_DIV;
            aa = WIDE_BITS'(mag) << 56;
            ab = den2_ff;
         end
         ST_QABS: begin
            areq.op = OP_DIV;
            aa = WIDE_BITS'(job_ff.sum_abs) << 40;
            ab = den_ff;
         end
         ST_QMS: begin
            areq.op = OP_DIV;
            aa = WIDE_BITS'(job_ff.sum_sq) << 32;
            ab = WIDE_BITS'(n);
         end
         ST_ROOT: begin
            areq.op = OP_SQRT;
            aa = p_ff;
         end
         ST_QRMS: begin
            areq.op = OP_DIV;
            aa = p_ff << 32;
            ab = WIDE_BITS'(dt_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issued_ff <= 1'b0;
         er_ff <= '0;
         es_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (areq.start) begin
            issued_ff <= 1'b1;
         end
         if (adone) begin
            issued_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  job_ff <= job;
                  state_ff <= ST_KSTEP;
               end
            end
            ST_WRITE: begin
               if (!out_valid_ff || rsp_pop) begin
                  out_valid_ff <= 1'b1;
                  er_ff <= er_in;
                  es_ff <= es_in;
                  o_fn_ff <= job_ff.frame_number;
                  o_er_ff <= er_in;
                  o_es_ff <= es_in;
                  o_mean_ff <= qmean_ff;
                  o_scaled_ff <= qscaled_ff;
                  o_abs_ff <= qabs_ff;
                  o_rms_ff <= qrms_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               if (adone) begin
                  unique case (state_ff)
                     ST_KSTEP: begin
                        p_ff <= ares;
                        state_ff <= ST_DT;
                     end
                     ST_DT: begin
                        dt_ff <= dt_new;
                        state_ff <= (dt_new == '0) ? ST_IDLE : ST_DTS;
                     end
                     ST_DTS: begin
                        dts_ff <= dt_new;
                        state_ff <= ST_DEN;
                     end
                     ST_DEN: begin
                        den_ff <= ares;
                        state_ff <= ST_DEN2;
                     end
                     ST_DEN2: begin
                        den2_ff <= ares;
                        state_ff <= ST_QMEAN;
                     end
                     ST_QMEAN: begin
                        qmean_ff <= sat_signed(ares, neg);
                        state_ff <= ST_QSCALED;
                     end
                     ST_QSCALED: begin
                        qscaled_ff <= sat_signed(ares, neg);
                        state_ff <= ST_QABS;
                     end
                     ST_QABS: begin
                        qabs_ff <= sat63(ares);
                        state_ff <= ST_QMS;
                     end
                     ST_QMS: begin
                        p_ff <= ares;
                        state_ff <= ST_ROOT;
                     end
                     ST_ROOT: begin
                        p_ff <= ares;
                        state_ff <= ST_QRMS;
                     end
                     default: begin
                        qrms_ff <= sat63(ares);
                        state_ff <= ST_WRITE;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_frame_number = o_fn_ff;
   assign rsp_total_real_time = o_er_ff;
   assign rsp_total_scaled_time = o_es_ff;
   assign rsp_mean_rate = o_mean_ff;
   assign rsp_mean_rate_scaled = o_scaled_ff;
   assign rsp_mean_abs_rate = o_abs_ff;
   assign rsp_rms_rate = o_rms_ff;

endmodule

// ----- hw/rtl/angular_velocity_frame_stats.sv -----
// one sample beat per cycle while req_full is low; a sample is folded into the frame sums
// after the s1, s2 and s3 pipeline registers; frame results come from the shared
// shift-add multiplier, 128-step divider and 64-step square root, run one after another
// up to 7 finished frames wait between the accumulator and the arithmetic sequencer
// synchronous reset clears counters, sums, times and queues; the angle memory is not cleared
module angular_velocity_frame_stats import avfs_pkg::*; #(
   parameter int MAX_PARTICLES = 4096,
   parameter int ANGLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [ANGLE_BITS-1:0] req_angle,
   input  logic signed [31:0]           req_frame_number,
   input  logic                         req_frame_last,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [31:0]           rsp_out_frame_number,
   output logic [62:0]                  rsp_total_real_time,
   output logic [62:0]                  rsp_total_scaled_time,
   output logic signed [63:0]           rsp_mean_rate,
   output logic signed [63:0]           rsp_mean_rate_scaled,
   output logic [62:0]                  rsp_mean_abs_rate,
   output logic [62:0]                  rsp_rms_rate,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [CNT_BITS-1:0] pc_ff;
   logic [31:0]         steps_ff;
   logic [47:0]         step_time_ff;
   logic [31:0]         dr_ff;
   logic                unwrapped_ff;

   logic [CNT_BITS-1:0] n_eff;
   logic                accept;
   logic                q_push, q_empty, q_pop, rsp_valid;
   job_type             q_in, q_head;
   logic [3:0]          q_count;

   assign csr_ready = 1'b1;
   assign req_full = (q_count >= 4'd4);
   assign accept = req_push && !req_full;
   assign rsp_empty = !rsp_valid;

   always_comb begin
      if (pc_ff == '0) begin
         n_eff = CNT_BITS'(1);
      end else if (17'(pc_ff) > 17'(MAX_PARTICLES)) begin
         n_eff = CNT_BITS'(MAX_PARTICLES);
      end else begin
         n_eff = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= CNT_BITS'(1);
         steps_ff <= 32'd10000;
         step_time_ff <= 48'd2814749767;
         dr_ff <= 32'd65536;
         unwrapped_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PARTICLE_COUNT:  pc_ff <= csr_wdata[CNT_BITS-1:0];
            CSR_STEPS_PER_FRAME: steps_ff <= csr_wdata[31:0];
            CSR_STEP_TIME:       step_time_ff <= csr_wdata[47:0];
            CSR_ROT_DIFFUSION:   dr_ff <= csr_wdata[31:0];
            CSR_UNWRAPPED_MODE:  unwrapped_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   avfs_front #(
      .MAX_PARTICLES (MAX_PARTICLES),
      .ANGLE_BITS    (ANGLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .angle        (req_angle),
      .frame_number (req_frame_number),
      .frame_last   (req_frame_last),
      .n            (n_eff),
      .unwrapped    (unwrapped_ff),
      .push         (q_push),
      .job          (q_in)
   );

   avfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_head),
      .count    (q_count)
   );

   avfs_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_ready             (!q_empty),
      .job                   (q_head),
      .job_pop               (q_pop),
      .n                     (n_eff),
      .steps                 (steps_ff),
      .step_time             (step_time_ff),
      .dr                    (dr_ff),
      .rsp_pop               (rsp_pop && rsp_valid),
      .rsp_valid             (rsp_valid),
      .rsp_out_frame_number  (rsp_out_frame_number),
      .rsp_total_real_time   (rsp_total_real_time),
      .rsp_total_scaled_time (rsp_total_scaled_time),
      .rsp_mean_rate         (rsp_mean_rate),
      .rsp_mean_rate_scaled  (rsp_mean_rate_scaled),
      .rsp_mean_abs_rate     (rsp_mean_abs_rate),
      .rsp_rms_rate          (rsp_rms_rate)
   );

endmodule

// ----- hw/rtl/avfs_check.sv -----
module avfs_check (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_out_frame_number,
   input logic [62:0] rsp_total_real_time
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result visible after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_frame_number)
         && $stable(rsp_total_real_time))
      else $error("waiting result beat changed");

endmodule

bind angular_velocity_frame_stats avfs_check u_avfs_check (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_out_frame_number (rsp_out_frame_number),
   .rsp_total_real_time  (rsp_total_real_time)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import avfs_pkg::*;

   localparam int MAXP = 4096;
   localparam int HOLD_CYCLES = 30000;
   localparam int SETTLE_CYCLES = 2500;
   localparam longint LIMIT = 4000000;
   localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -64'sh8000_0000_0000;

   typedef struct {
      logic signed [31:0] ang;
      logic signed [31:0] fn;
      bit                 last;
   } sample_t;

   typedef struct {
      logic signed [31:0] frame_no;
      logic [62:0]        real_t;
      logic [62:0]        scaled_t;
      logic [63:0]        mean;
      logic [63:0]        mean_sc;
      logic [62:0]        mean_abs;
      logic [62:0]        rms;
   } frame_stats_t;

   logic clock;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [31:0] req_angle = '0;
   logic signed [31:0] req_frame_number = '0;
   logic req_frame_last = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_out_frame_number;
   logic [62:0] rsp_total_real_time;
   logic [62:0] rsp_total_scaled_time;
   logic signed [63:0] rsp_mean_rate;
   logic signed [63:0] rsp_mean_rate_scaled;
   logic [62:0] rsp_mean_abs_rate;
   logic [62:0] rsp_rms_rate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   angular_velocity_frame_stats dut (.*);

   // stimulus and expectation stores
   sample_t pending_samples[$];
   frame_stats_t expected_stats[$];
   int errors = 0;
   longint cycles = 0;
   bit calm = 1'b0;
   bit req_taken = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // predictor state
   logic [12:0] cfg_count = 13'd1;
   logic [31:0] cfg_steps = 32'd10000;
   logic [47:0] cfg_dt = 48'd2814749767;
   logic [31:0] cfg_dr = 32'd65536;
   bit cfg_raw = 1'b1;
   logic signed [31:0] seen_angle[MAXP];
   int unsigned slot = 0;
   logic signed [31:0] last_fn = '0;
   bit have_frame = 1'b0;
   longint acc_delta = 0;
   longint unsigned acc_abs = 0;
   longint unsigned acc_sq = 0;
   logic [62:0] clock_real = '0;
   logic [62:0] clock_scaled = '0;

   // generator state
   int gen_angle[MAXP];
   int unsigned gen_pos = 0;
   int unsigned gen_hwm = 0;
   bit gen_loaded = 1'b0;
   logic signed [31:0] gen_fn = '0;
   int items_sent = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned eff_n();
      if (cfg_count == 0) begin
         return 1;
      end
      if (cfg_count > MAXP) begin
         return MAXP;
      end
      return cfg_count;
   endfunction

   function automatic logic [62:0] cap63(input logic [127:0] x);
      return (x[127:63] != '0) ? '1 : x[62:0];
   endfunction

   function automatic logic [63:0] cap_signed(input logic [127:0] x, input bit neg);
      if (!neg) begin
         return {1'b0, cap63(x)};
      end
      if (x > 128'h8000_0000_0000_0000) begin
         return 64'h8000_0000_0000_0000;
      end
      return 64'd0 - x[63:0];
   endfunction

   function automatic logic [62:0] add63(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? '1 : s[62:0];
   endfunction

   function automatic logic [127:0] int_sqrt(input logic [127:0] x);
      logic [127:0] res, t;
      res = '0;
      for (int i = 63; i >= 0; i--) begin
         t = res | (128'd1 << i);
         if (t * t <= x) begin
            res = t;
         end
      end
      return res;
   endfunction

   task automatic absorb_sample(input logic signed [31:0] ang, input logic signed [31:0] fn,
                                input bit last);
      int unsigned n;
      longint d, s;
      longint unsigned m, sq;
      logic [64:0] sq_sum;
      logic [63:0] k, kx, mag;
      logic [127:0] den, root;
      logic [62:0] dt, dts;
      logic [31:0] dr;
      bit neg;
      frame_stats_t r;
      n = eff_n();
      if (slot < n) begin
         if (have_frame) begin
            d = longint'(ang) - longint'(seen_angle[slot]);
            if (!cfg_raw) begin
               if (d > PI_Q) begin
                  d -= TWO_PI_Q;
               end else if (d <= -PI_Q) begin
                  d += TWO_PI_Q;
               end
            end
            s = acc_delta + d;
            acc_delta = (s > ACC_HI) ? ACC_HI : ((s < ACC_LO) ? ACC_LO : s);
            m = (d < 0) ? -d : d;
            acc_abs += m;
            if (acc_abs > 64'hFFFF_FFFF_FFFF) begin
               acc_abs = 64'hFFFF_FFFF_FFFF;
            end
            if (m > 64'hFFFF_FFFF) begin
               m = 64'hFFFF_FFFF;
            end
            sq = (m * m) >> 16;
            sq_sum = {1'b0, acc_sq} + {1'b0, sq};
            acc_sq = sq_sum[64] ? '1 : sq_sum[63:0];
         end
         seen_angle[slot] = ang;
         slot++;
      end
      if (!last) begin
         return;
      end
      if (have_frame && fn > last_fn) begin
         k = 64'(longint'(fn) - longint'(last_fn));
         kx = k * {32'd0, cfg_steps};
         dt = cap63((128'(kx) * 128'(cfg_dt)) >> 16);
         if (dt != 0) begin
            dts = cap63((128'(dt) * 128'(cfg_dr)) >> 16);
            dr = (cfg_dr == 0) ? 32'd1 : cfg_dr;
            neg = acc_delta < 0;
            mag = neg ? 64'(-acc_delta) : 64'(acc_delta);
            den = 128'(n) * 128'(dt);
            clock_real = add63(clock_real, dt);
            clock_scaled = add63(clock_scaled, dts);
            r.frame_no = fn;
            r.real_t = clock_real;
            r.scaled_t = clock_scaled;
            r.mean = cap_signed((128'(mag) << 40) / den, neg);
            r.mean_sc = cap_signed((128'(mag) << 56) / (den * 128'(dr)), neg);
            r.mean_abs = cap63((128'(acc_abs) << 40) / den);
            root = int_sqrt((128'(acc_sq) << 32) / 128'(n));
            r.rms = cap63((root << 32) / 128'(dt));
            expected_stats.push_back(r);
         end
      end
      have_frame = 1'b1;
      last_fn = fn;
      slot = 0;
      acc_delta = 0;
      acc_abs = 0;
      acc_sq = 0;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 80);
   endfunction

   // input side
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      req_taken = req_push && !req_full;
      if (req_taken) begin
         absorb_sample(req_angle, req_frame_number, req_frame_last);
         void'(pending_samples.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
      end else if (req_gap > 0) begin
         req_gap--;
         req_push <= 1'b0;
      end else if (pending_samples.size() > 0) begin
         req_push <= 1'b1;
         req_angle <= pending_samples[0].ang;
         req_frame_number <= pending_samples[0].fn;
         req_frame_last <= pending_samples[0].last;
         req_gap = pick_gap();
      end else begin
         req_push <= 1'b0;
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      frame_stats_t e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_stats.size() == 0) begin
            $error("result beat with nothing expected, frame %0d", rsp_out_frame_number);
            errors++;
         end else begin
            e = expected_stats.pop_front();
            if (rsp_out_frame_number !== e.frame_no) begin
               $error("out_frame_number expected %0d got %0d", e.frame_no,
                      rsp_out_frame_number);
               errors++;
            end
            if (rsp_total_real_time !== e.real_t) begin
               $error("total_real_time expected %h got %h", e.real_t, rsp_total_real_time);
               errors++;
            end
            if (rsp_total_scaled_time !== e.scaled_t) begin
               $error("total_scaled_time expected %h got %h", e.scaled_t,
                      rsp_total_scaled_time);
               errors++;
            end
            if (rsp_mean_rate !== e.mean) begin
               $error("mean_rate expected %h got %h", e.mean, rsp_mean_rate);
               errors++;
            end
            if (rsp_mean_rate_scaled !== e.mean_sc) begin
               $error("mean_rate_scaled expected %h got %h", e.mean_sc, rsp_mean_rate_scaled);
               errors++;
            end
            if (rsp_mean_abs_rate !== e.mean_abs) begin
               $error("mean_abs_rate expected %h got %h", e.mean_abs, rsp_mean_abs_rate);
               errors++;
            end
            if (rsp_rms_rate !== e.rms) begin
               $error("rms_rate expected %h got %h", e.rms, rsp_rms_rate);
               errors++;
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PARTICLE_COUNT: cfg_count = val[12:0];
         CSR_STEPS_PER_FRAME: cfg_steps = val[31:0];
         CSR_STEP_TIME: cfg_dt = val[47:0];
         CSR_ROT_DIFFUSION: cfg_dr = val[31:0];
         CSR_UNWRAPPED_MODE: cfg_raw = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [12:0] count, input logic [31:0] steps,
                            input logic [47:0] dt, input logic [31:0] dr, input bit raw);
      write_csr(CSR_PARTICLE_COUNT, 48'(count));
      write_csr(CSR_STEPS_PER_FRAME, 48'(steps));
      write_csr(CSR_STEP_TIME, dt);
      write_csr(CSR_ROT_DIFFUSION, 48'(dr));
      write_csr(CSR_UNWRAPPED_MODE, 48'(raw));
   endtask

   task automatic add_sample(input logic signed [31:0] ang, input logic signed [31:0] fn,
                             input bit last);
      sample_t s;
      s.ang = ang;
      s.fn = fn;
      s.last = last;
      pending_samples.push_back(s);
      items_sent++;
      if (gen_pos < eff_n()) begin
         gen_angle[gen_pos] = ang;
         if (gen_pos + 1 > gen_hwm) begin
            gen_hwm = gen_pos + 1;
         end
      end
      gen_pos++;
      if (last) begin
         gen_pos = 0;
         gen_loaded = 1'b1;
         gen_fn = fn;
      end
   endtask

   task automatic send_random_frame();
      int unsigned n, len, pick;
      logic signed [31:0] fn, ang;
      n = eff_n();
      pick = $urandom_range(0, 9);
      if (n <= 24) begin
         len = (pick < 8) ? n : ((pick == 8) ? $urandom_range(1, n) : n + $urandom_range(1, 3));
      end else begin
         len = $urandom_range(1, 6);
      end
      // never read a store entry that no frame has written
      if (gen_loaded && len > gen_hwm && n > gen_hwm) begin
         len = gen_hwm;
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         fn = gen_fn + int'($urandom_range(1, 4));
      end else if (pick < 17) begin
         fn = gen_fn - int'($urandom_range(0, 3));
      end else if (pick < 19) begin
         fn = $urandom;
      end else begin
         fn = gen_fn + int'($urandom_range(100, 100000));
      end
      for (int unsigned p = 0; p < len; p++) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            ang = gen_angle[p % MAXP] + int'($urandom_range(0, 2097152)) - 1048576;
         end else if (pick < 17) begin
            ang = int'($urandom_range(0, 105414357)) - 52707179;
         end else begin
            ang = $urandom;
         end
         add_sample(ang, fn, p == len - 1);
      end
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || expected_stats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [12:0] count;
      logic [31:0] steps, dr;
      logic [47:0] dt;
      int target;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrapped mode, widest timestep, zero diffusion
      configure(13'd24, 32'd1, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0);
      add_sample(32'sh8000_0000, 32'sd10, 1'b0);
      add_sample(32'sh7FFF_FFFF, 32'sd10, 1'b0);
      add_sample(32'sd0, 32'sd10, 1'b0);
      add_sample(32'sd52707179, 32'sd10, 1'b0);
      for (int i = 4; i < 24; i++) begin
         add_sample(int'($urandom_range(0, 105414357)) - 52707179, 32'sd10, i == 23);
      end
      // short frame hitting both wrap directions and both pi edges
      add_sample(32'sd0, 32'sd11, 1'b0);
      add_sample(32'sh8000_0000, 32'sd11, 1'b0);
      add_sample(-32'sd52707179, 32'sd11, 1'b0);
      add_sample(32'sd105414358, 32'sd11, 1'b1);
      add_sample(32'sd1000, 32'sd11, 1'b0);
      add_sample(-32'sd1000, 32'sd11, 1'b1);
      add_sample(32'sd77, 32'sd9, 1'b1);
      drain();

      // raw mode, count of zero, extreme steps and diffusion
      configure(13'd0, 32'hFFFF_FFFF, 48'd1, 32'hFFFF_FFFF, 1'b1);
      add_sample(32'sd3, 32'sh8000_0000, 1'b1);
      add_sample(-32'sd5, 32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sd9, 32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sd11, 32'sh7FFF_FFFF, 1'b1);
      drain();

      // frame time that truncates to zero
      write_csr(CSR_STEPS_PER_FRAME, 48'd1);
      add_sample(32'sd4, 32'sd0, 1'b1);
      add_sample(32'sd8, 32'sd1, 1'b1);
      drain();

      for (int ph = 0; ph < 11; ph++) begin
         case ($urandom_range(0, 9))
            0: count = 13'd0;
            1: count = 13'd8191;
            2: count = 13'd4096;
            3: count = $urandom_range(25, 1000);
            4, 5: count = $urandom_range(9, 24);
            default: count = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 3))
            0: steps = 32'd1;
            1: steps = 32'hFFFF_FFFF;
            2: steps = $urandom_range(1, 20000);
            default: steps = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: dt = 48'd1;
            1: dt = 48'hFFFF_FFFF_FFFF;
            2: dt = 48'({8'($urandom_range(0, 255)), $urandom});
            default: dt = 48'd2814749767;
         endcase
         case ($urandom_range(0, 3))
            0: dr = 32'd1;
            1: dr = 32'hFFFF_FFFF;
            2: dr = 32'd65536;
            default: dr = $urandom;
         endcase
         if (ph == 2) begin
            count = 13'd2;
            steps = 32'd10000;
            dt = 48'd2814749767;
            dr = 32'd65536;
         end
         configure(count, steps, dt, dr, $urandom_range(0, 1));
         calm = ($urandom_range(0, 3) == 0);
         if (ph == 2) begin
            calm = 1'b1;
            hold_ask++;
         end
         target = items_sent + 118;
         while (items_sent < target) begin
            send_random_frame();
         end
         drain();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/avfs_pkg.sv
hw/rtl/avfs_front.sv
hw/rtl/avfs_queue.sv
hw/rtl/avfs_arith.sv
hw/rtl/avfs_back.sv
hw/rtl/angular_velocity_frame_stats.sv
hw/rtl/avfs_check.sv
bench/tb_top.sv
